[rtl/iiel_pkg.sv]
// ----------------------------------------------------------------------------
// iiel_pkg
// Shared codes and controller/datapath interface types for the list core.
// ----------------------------------------------------------------------------
package iiel_pkg;

    // request opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADIDX = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // field widths of the stream words
    localparam int POS_BITS   = 4;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 5;

    // what the accepted request turns into once checked
    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_ERASE  = 3'd3,
        ACT_READ   = 3'd4
    } act_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch the incoming request
        logic decide;   // register action/status, load shift pointers
        logic step;     // read one source entry of the shift
        logic finish;   // final write and count update
        logic respond;  // load the output register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        act_t action;   // decision for the latched request
        logic cnt_zero; // no entries left to move
        logic out_free; // output register can take a word
    } dp_stat_t;

endpackage

[rtl/iiel_ram.sv]
// ----------------------------------------------------------------------------
// iiel_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iiel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/iiel_dp.sv]
// ----------------------------------------------------------------------------
// iiel_dp
// Datapath: request registers, list count, shift pointers, entry RAM and
// output register.
// ----------------------------------------------------------------------------
module iiel_dp
    import iiel_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctl_cmd_t              cmd,
    output dp_stat_t              stat,
    input  logic [1:0]            in_op,
    input  logic [POS_BITS-1:0]   in_position,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [VALUE_BITS-1:0] out_read_data,
    output logic [COUNT_BITS-1:0] out_count,
    output logic [1:0]            out_status
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

    logic [1:0]            op_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [WORD_BITS-1:0]  val_reg;
    logic [CW-1:0]         used_reg,   used_next;
    act_t                  act_reg;
    logic [1:0]            status_reg;
    logic [CW-1:0]         src_reg,    src_next;
    logic [CW-1:0]         cnt_reg,    cnt_next;
    logic                  pend_reg;
    logic [AW-1:0]         pend_addr_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [VALUE_BITS-1:0] rd_out_reg;
    logic [COUNT_BITS-1:0] count_out_reg;
    logic [1:0]            status_out_reg;

    act_t                  act_c;
    logic [1:0]            st_c;
    logic [CMPW-1:0]       pos_x, used_x;
    logic [CW-1:0]         pos_c;
    logic                  full, empty;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr, tgt_addr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

    // request check
    always_comb begin
        pos_x  = CMPW'(pos_reg);
        used_x = CMPW'(used_reg);
        pos_c  = CW'(pos_x);
        full   = (used_reg == CW'(DEPTH));
        empty  = (used_reg == '0);
        act_c  = ACT_NONE;
        st_c   = ST_OK;
        unique case (op_reg)
            OP_APPEND: begin
                if (full) st_c = ST_FULL;
                else      act_c = ACT_APPEND;
            end
            OP_INSERT: begin
                if (pos_x > used_x) st_c = ST_BADIDX;
                else if (full)      st_c = ST_FULL;
                else                act_c = ACT_INSERT;
            end
            OP_ERASE: begin
                if (empty)                st_c = ST_EMPTY;
                else if (pos_x >= used_x) st_c = ST_BADIDX;
                else                      act_c = ACT_ERASE;
            end
            default: begin
                if (empty)                st_c = ST_EMPTY;
                else if (pos_x >= used_x) st_c = ST_BADIDX;
                else                      act_c = ACT_READ;
            end
        endcase
    end

    // shift pointers: insert walks down from the tail, erase walks up
    always_comb begin
        src_next = src_reg;
        cnt_next = cnt_reg;
        if (cmd.decide) begin
            if (op_reg == OP_INSERT) begin
                src_next = used_reg - CW'(1);
                cnt_next = used_reg - pos_c;
            end else begin
                src_next = pos_c + CW'(1);
                cnt_next = used_reg - pos_c - CW'(1);
            end
        end else if (cmd.step) begin
            src_next = (act_reg == ACT_INSERT) ? src_reg - CW'(1) : src_reg + CW'(1);
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_comb begin
        used_next = used_reg;
        if (cmd.finish) begin
            unique case (act_reg)
                ACT_APPEND, ACT_INSERT: used_next = used_reg + CW'(1);
                ACT_ERASE:              used_next = used_reg - CW'(1);
                default:                used_next = used_reg;
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.respond)   m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            used_reg     <= used_next;
            pend_reg     <= cmd.step;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= in_op;
            pos_reg <= in_position;
            val_reg <= WORD_BITS'(in_value);
        end
        if (cmd.decide) begin
            act_reg    <= act_c;
            status_reg <= st_c;
        end
        src_reg <= src_next;
        cnt_reg <= cnt_next;
        if (cmd.step) begin
            pend_addr_reg <= (act_reg == ACT_INSERT) ? AW'(src_reg + CW'(1))
                                                     : AW'(src_reg - CW'(1));
        end
        if (cmd.respond) begin
            rd_out_reg     <= (act_reg == ACT_READ) ? VALUE_BITS'(ram_rdata) : '0;
            count_out_reg  <= COUNT_BITS'(used_reg);
            status_out_reg <= status_reg;
        end
    end

    // entry store; moved words are written in the cycle after their read
    always_comb begin
        tgt_addr  = (act_reg == ACT_APPEND) ? AW'(used_reg) : AW'(pos_reg);
        ram_we    = pend_reg || (cmd.finish &&
                    (act_reg == ACT_APPEND || act_reg == ACT_INSERT));
        ram_waddr = pend_reg ? pend_addr_reg : tgt_addr;
        ram_wdata = pend_reg ? ram_rdata : val_reg;
        ram_raddr = cmd.step ? AW'(src_reg) : AW'(pos_reg);
    end

    iiel_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.action   = act_c;
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid      = m_tvalid_reg;
    assign out_read_data = rd_out_reg;
    assign out_count     = count_out_reg;
    assign out_status    = status_out_reg;

endmodule

[rtl/iiel_ctrl.sv]
// ----------------------------------------------------------------------------
// iiel_ctrl
// Controller: sequences check, shift, final write and response per request.
// ----------------------------------------------------------------------------
module iiel_ctrl
    import iiel_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_SHIFT  = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_FINAL  = 7'b0010000,
        S_RDWAIT = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                unique case (stat.action)
                    ACT_APPEND:            state_next = S_FINAL;
                    ACT_INSERT, ACT_ERASE: state_next = S_SHIFT;
                    ACT_READ:              state_next = S_RDWAIT;
                    default:               state_next = S_RESP;
                endcase
            end
            S_SHIFT: begin
                if (stat.cnt_zero) state_next = S_DRAIN;
                else               cmd.step   = 1'b1;
            end
            S_DRAIN:  state_next = S_FINAL;   // spare state after the last move
            S_FINAL: begin
                cmd.finish = 1'b1;
                state_next = S_RESP;
            end
            S_RDWAIT: state_next = S_RESP;
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule

[rtl/indexed_insert_erase_list_core.sv]
// ----------------------------------------------------------------------------
// indexed_insert_erase_list_core
// Fixed-depth ordered list of words with append, insert, erase and read.
// ----------------------------------------------------------------------------
// One request word in, one result word out. Requests are handled one at a
// time; the entries live in a single RAM with one write and one registered
// read port, so an insert or erase moves the entries behind the position one
// word per cycle. An insert or erase moves M entries, where M is count -
// position for insert and count - position - 1 for erase. A new request
// is taken while the previous result still waits in the output register;
// the core only holds in its response step if that register is still
// occupied. Entries are never read before they are written, so the RAM
// needs no clearing after reset.
// ----------------------------------------------------------------------------
module indexed_insert_erase_list_core
    import iiel_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] position, [35:4] value, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] read_data, [36:32] count, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    ctl_cmd_t              cmd;
    dp_stat_t              stat;
    logic [VALUE_BITS-1:0] read_data;
    logic [COUNT_BITS-1:0] count;
    logic [1:0]            status;

    // sequencing
    iiel_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage, checks and output register
    iiel_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_op         (s_tuser),
        .in_position   (s_tdata[POS_BITS-1:0]),
        .in_value      (s_tdata[POS_BITS +: VALUE_BITS]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .out_read_data (read_data),
        .out_count     (count),
        .out_status    (status)
    );

    assign m_tdata = {3'b000, count, read_data};
    assign m_tuser = status;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // one request at a time: no second word right after an accepted one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous still in progress");

    // shift never reads past the entries that have to move
    a_step_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !stat.cnt_zero)
        else $error("shift step with no entries left to move");

    // result only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.respond |-> stat.out_free)
        else $error("result overwrote a pending output word");

    // a full status always reports a full list
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[36:32] == COUNT_BITS'(DEPTH)))
        else $error("full status with count below depth");

endmodule
